// ===== hw/rtl/rrfs_pkg.sv =====
`timescale 1ns / 1ps
package rrfs_pkg;

    typedef enum logic [1:0]
    {
        MODE_NORMAL,
        MODE_QUOTED,
        MODE_ESCAPED
    } mode_t;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_U      = 8'h55;
    localparam logic [7:0] CHAR_L      = 8'h4C;

    localparam int ROW_BITS    = 24;
    localparam int COL_BITS    = 8;
    localparam int FIELD_BITS  = 16;
    localparam int CFG_BITS    = 9;
    localparam int SKIP_BYTES  = 2;
    localparam int CQ_BITS     = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int TDATA_BITS  = 72;
    localparam int TUSER_BITS  = 1;

    localparam logic [CFG_BITS-1:0] COLUMN_COUNT_RESET = 9'd1;

    // One parse command from the front to the back
    typedef struct packed
    {
        logic       has_byte;
        logic       last;
        logic       is_quote;
        logic       is_comma;
        logic       is_bslash;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed
    {
        logic [ROW_BITS-1:0]   row_index;
        logic [COL_BITS-1:0]   column_index;
        logic [FIELD_BITS-1:0] field_start;
        logic [FIELD_BITS-1:0] field_length;
        logic                  is_null;
        logic                  too_many_columns;
    } desc_t;

endpackage

// ===== hw/rtl/result_row_field_splitter.sv =====
`timescale 1ns / 1ps
// Field splitter for comma separated text result lines.
// Slave stream: one byte per transaction in s_tdata, s_tlast on the last
// byte of a line. Master stream: one field descriptor per transaction in
// m_tdata; m_tuser flags a column beyond the configured count, after which
// the rest of that line yields nothing. cfg_wr_en/cfg_wr_data write the
// expected column count; write it only while the block is idle.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// A byte is held until the next byte of its line arrives (that is how the
// next to last byte is recognised). The transaction carrying that next
// byte pushes a command into the queue; the parser takes it from the queue
// and loads the descriptor into the output register, which drives m_tvalid.
// The parser's state update sets the one-byte-per-cycle figure.
// Reset clears the line state, the row counter and both streams; the column
// count returns to 1. When the receiver stalls, the output register holds,
// the queue fills, and s_tready falls once the queue is full; nothing is
// lost or repeated.
module result_row_field_splitter
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int POSITION_BITS = 16,
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rrfs_pkg::CFG_BITS-1:0]     cfg_wr_data,   // column_count
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,       // data_byte
    input  logic                              s_tlast,       // line_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // row_index, column_index, field_start, field_length, is_null, zero pad
    output logic [rrfs_pkg::TDATA_BITS-1:0]   m_tdata,
    output logic [rrfs_pkg::TUSER_BITS-1:0]   m_tuser        // too_many_columns
);
    import rrfs_pkg::*;

    localparam int USED_BITS = ROW_BITS + COL_BITS + 2 * FIELD_BITS + 1;

    logic [CFG_BITS-1:0] column_count_reg, column_count_next;
    logic                f_valid, f_ready, b_valid, b_ready;
    cmd_t                f_cmd, b_cmd;
    desc_t               desc;

    assign column_count_next = cfg_wr_en ? cfg_wr_data : column_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            column_count_reg <= COLUMN_COUNT_RESET;
        else
            column_count_reg <= column_count_next;
    end

    rrfs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    rrfs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_cmd)
    );

    rrfs_back
    #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .POSITION_BITS (POSITION_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .column_count (column_count_reg),
        .cmd_valid    (b_valid),
        .cmd_ready    (b_ready),
        .cmd          (b_cmd),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .desc         (desc)
    );

    assign m_tdata = {{(TDATA_BITS - USED_BITS){1'b0}}, desc.is_null, desc.field_length,
                      desc.field_start, desc.column_index, desc.row_index};
    assign m_tuser = TUSER_BITS'(desc.too_many_columns);

endmodule

// ===== hw/rtl/rrfs_front.sv =====
`timescale 1ns / 1ps
module rrfs_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic          s_tlast,   // line_end
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output rrfs_pkg::cmd_t cmd
);
    import rrfs_pkg::*;

    localparam int SKIP_W = $clog2(SKIP_BYTES + 1);

    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [7:0]        held_byte_reg, held_byte_next;
    logic              held_valid_reg, held_valid_next;
    logic              accept;

    assign s_tready  = cmd_ready;
    assign accept    = s_tvalid & cmd_ready;
    // a transaction carries the held byte, or a bare line end
    assign cmd_valid = s_tvalid & (held_valid_reg | s_tlast);

    always_comb
    begin
        cmd.has_byte  = held_valid_reg;
        cmd.last      = s_tlast;
        cmd.is_quote  = (held_byte_reg == CHAR_QUOTE);
        cmd.is_comma  = (held_byte_reg == CHAR_COMMA);
        cmd.is_bslash = (held_byte_reg == CHAR_BSLASH);
        cmd.data      = held_byte_reg;
    end

    always_comb
    begin
        skip_next       = skip_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                skip_next       = '0;
                held_byte_next  = '0;
                held_valid_next = 1'b0;
            end
            else if (skip_reg == SKIP_W'(SKIP_BYTES))
            begin
                held_byte_next  = s_tdata;
                held_valid_next = 1'b1;
            end
            else
            begin
                skip_next = skip_reg + SKIP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg       <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            skip_reg       <= skip_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ===== hw/rtl/rrfs_queue.sv =====
`timescale 1ns / 1ps
module rrfs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rrfs_pkg::cmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rrfs_pkg::cmd_t out_data
);
    import rrfs_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/rrfs_back.sv =====
`timescale 1ns / 1ps
module rrfs_back
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int POSITION_BITS = 16,
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rrfs_pkg::CFG_BITS-1:0]   column_count,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  rrfs_pkg::cmd_t                  cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output rrfs_pkg::desc_t                 desc
);
    import rrfs_pkg::*;

    localparam int PB   = POSITION_BITS;
    localparam int LW   = PB + 2;
    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int LIMW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int NULL_SPAN = (HISTORY_DEPTH - 3 < (1 << CQ_BITS)) ?
                               (HISTORY_DEPTH - 3) : (1 << CQ_BITS);
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [PB-1:0] CUR_MAX = POS_MAX - PB'(1);
    localparam logic [PB-1:0] TOKEN_RESET = PB'(SKIP_BYTES);
    localparam logic [CQ_BITS-1:0] CQ_MAX = '1;

    mode_t               mode_reg, mode_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [PB-1:0]       tok_reg, tok_next;
    logic [PB-1:0]       cur_reg, cur_next;
    logic [CQ_BITS-1:0]  cq_reg, cq_next;
    logic [7:0]          hist_reg [HISTORY_DEPTH];
    logic [7:0]          hist_next [HISTORY_DEPTH];
    logic [ROW_BITS-1:0] line_reg, line_next;
    logic                failed_reg, failed_next;
    logic                out_valid_reg, out_valid_next;
    desc_t               desc_reg, desc_next;

    logic                take, parse, emit, over;
    logic [LIMW-1:0]     limit;
    logic [LW-1:0]       len;
    logic                len_le0, len_is4, word_hit;
    logic [NULL_SPAN-1:0] word_match;

    assign cmd_ready = !out_valid_reg || m_tready;
    assign take      = cmd_valid & cmd_ready;
    assign parse     = take & cmd.has_byte & !failed_reg;
    assign emit      = parse & (mode_reg == MODE_NORMAL) & !cmd.is_quote
                     & (cmd.is_comma | cmd.last);
    assign m_tvalid  = out_valid_reg;
    assign desc      = desc_reg;

    always_comb
    begin
        limit = (LIMW'(column_count) > LIMW'(MAX_COLUMNS)) ?
                LIMW'(MAX_COLUMNS) : LIMW'(column_count);
        over  = (LIMW'(col_reg) >= limit);
    end

    // length is signed: the begin mark can run ahead of the position
    always_comb
    begin
        len     = LW'(cur_reg) - LW'(tok_reg) - LW'(cq_reg);
        len_le0 = len[LW-1] | (len == '0);
        len_is4 = (len == LW'(4));
    end

    // NULL spelt out in history, closing quotes sitting on top of it
    always_comb
    begin
        for (int k = 0; k < NULL_SPAN; k++)
            word_match[k] = (hist_reg[k + 3] == CHAR_N) && (hist_reg[k + 2] == CHAR_U)
                         && (hist_reg[k + 1] == CHAR_L) && (hist_reg[k] == CHAR_L);
        word_hit = 1'b0;
        for (int k = 0; k < NULL_SPAN; k++)
            if (cq_reg == CQ_BITS'(k))
                word_hit = word_match[k];
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (take && cmd.last)
            mode_next = MODE_NORMAL;
        else if (parse)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                    if (cmd.is_quote)
                        mode_next = MODE_QUOTED;
                MODE_QUOTED:
                begin
                    if (cmd.is_quote)
                        mode_next = MODE_NORMAL;
                    else if (cmd.is_bslash)
                        mode_next = MODE_ESCAPED;
                end
                MODE_ESCAPED:
                    mode_next = MODE_QUOTED;
                default:
                    mode_next = MODE_NORMAL;
            endcase
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        tok_next       = tok_reg;
        cur_next       = cur_reg;
        cq_next        = cq_reg;
        line_next      = line_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg;
        desc_next      = desc_reg;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_next[i] = hist_reg[i];

        if (take && cmd.has_byte)
            cur_next = (cur_reg == CUR_MAX) ? cur_reg : cur_reg + PB'(1);

        if (parse)
        begin
            hist_next[0] = cmd.data;
            for (int i = 1; i < HISTORY_DEPTH; i++)
                hist_next[i] = hist_reg[i - 1];
            if (mode_reg == MODE_NORMAL && cmd.is_quote)
                tok_next = (tok_reg == POS_MAX) ? tok_reg : tok_reg + PB'(1);
            if (mode_reg == MODE_QUOTED && cmd.is_quote && cq_reg != CQ_MAX)
                cq_next = cq_reg + CQ_BITS'(1);
        end

        if (emit)
        begin
            desc_next.row_index    = line_reg;
            desc_next.column_index = COL_BITS'(col_reg);
            if (over)
            begin
                desc_next.field_start      = '0;
                desc_next.field_length     = '0;
                desc_next.is_null          = 1'b0;
                desc_next.too_many_columns = 1'b1;
                failed_next                = 1'b1;
            end
            else
            begin
                desc_next.field_start      = FIELD_BITS'(tok_reg);
                desc_next.field_length     = len_le0 ? '0 : FIELD_BITS'(len);
                desc_next.is_null          = len_le0 | (len_is4 & word_hit);
                desc_next.too_many_columns = 1'b0;
                col_next = col_reg + CW'(1);
                tok_next = (cur_reg == CUR_MAX) ? POS_MAX : cur_reg + PB'(2);
                cq_next  = '0;
            end
        end

        if (take)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;

        // line end: restore the line state, advance the row
        if (take && cmd.last)
        begin
            col_next    = '0;
            tok_next    = TOKEN_RESET;
            cur_next    = TOKEN_RESET;
            cq_next     = '0;
            failed_next = 1'b0;
            line_next   = line_reg + ROW_BITS'(1);
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            col_reg       <= '0;
            tok_reg       <= TOKEN_RESET;
            cur_reg       <= TOKEN_RESET;
            cq_reg        <= '0;
            line_reg      <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            col_reg       <= col_next;
            tok_reg       <= tok_next;
            cur_reg       <= cur_next;
            cq_reg        <= cq_next;
            line_reg      <= line_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= hist_next[i];
        end
    end

endmodule

// ===== tb/tb_result_row_field_splitter.sv =====
`timescale 1ns / 1ps
module tb_result_row_field_splitter;
    import rrfs_pkg::*;

    localparam int POS_LIMIT = 65535;
    localparam int COL_LIMIT = 256;
    localparam int HIST      = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_BITS-1:0]   cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // data_byte
    logic                  s_tlast;   // line_end
    logic                  m_tvalid;
    logic                  m_tready;
    // row_index, column_index, field_start, field_length, is_null, zero pad
    logic [TDATA_BITS-1:0] m_tdata;
    logic [TUSER_BITS-1:0] m_tuser;   // too_many_columns

    result_row_field_splitter dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Predictor state of the splitter
    logic [CFG_BITS-1:0] col_cfg;
    mode_t               pmode;
    int                  col_num;
    int                  tok_start;
    int                  pos;
    int                  close_q;
    logic [7:0]          hold_b;
    bit                  hold_v;
    logic [7:0]          hist [HIST];
    logic [ROW_BITS-1:0] row_num;
    bit                  row_dead;

    desc_t      fields_expected [$];
    desc_t      want;
    logic [7:0] line_buf [$];
    int         errors;
    int         bytes_sent;
    bit         gaps_off;
    bit         rx_steady;
    int         hold_off;
    int         stall_left;
    int         r;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL result_row_field_splitter");
        $finish;
    end

    function automatic int pos_sat(input int v);
        return (v > POS_LIMIT) ? POS_LIMIT : v;
    endfunction

    task automatic restart_line();
        pmode     = MODE_NORMAL;
        col_num   = 0;
        tok_start = SKIP_BYTES;
        pos       = 0;
        close_q   = 0;
        hold_b    = '0;
        hold_v    = 1'b0;
        row_dead  = 1'b0;
        for (int i = 0; i < HIST; i++)
            hist[i] = '0;
    endtask

    task automatic reset_splitter_state();
        col_cfg = COLUMN_COUNT_RESET;
        row_num = '0;
        restart_line();
    endtask

    // Advance the predictor by one accepted byte; queue any descriptor it yields
    task automatic split_predict(input logic [7:0] b, input bit last);
        desc_t      d;
        int         cur;
        int         len;
        int         lim;
        bit         ends;
        logic [7:0] hb;
        if (hold_v && !row_dead)
        begin
            hb   = hold_b;
            cur  = pos - 1;
            ends = 1'b0;
            case (pmode)
                MODE_NORMAL:
                    if (hb == CHAR_QUOTE)
                    begin
                        pmode     = MODE_QUOTED;
                        tok_start = pos_sat(tok_start + 1);
                    end
                    else if (hb == CHAR_COMMA || last)
                        ends = 1'b1;
                MODE_ESCAPED:
                    pmode = MODE_QUOTED;
                default:
                    if (hb == CHAR_QUOTE)
                    begin
                        pmode = MODE_NORMAL;
                        if (close_q < 7)
                            close_q++;
                    end
                    else if (hb == CHAR_BSLASH)
                        pmode = MODE_ESCAPED;
            endcase
            if (ends)
            begin
                lim            = (col_cfg > COL_LIMIT) ? COL_LIMIT : int'(col_cfg);
                d              = '0;
                d.row_index    = row_num;
                d.column_index = col_num[7:0];
                if (col_num >= lim)
                begin
                    d.too_many_columns = 1'b1;
                    row_dead           = 1'b1;
                end
                else
                begin
                    len       = cur - tok_start - close_q;
                    d.is_null = (len < 1);
                    // the four content bytes sit behind the closing quotes
                    if (len == 4 && close_q + 3 < HIST)
                        d.is_null = (hist[close_q + 3] == CHAR_N) &&
                                    (hist[close_q + 2] == CHAR_U) &&
                                    (hist[close_q + 1] == CHAR_L) &&
                                    (hist[close_q] == CHAR_L);
                    d.field_start  = tok_start[15:0];
                    d.field_length = (len < 1) ? '0 : len[15:0];
                    col_num++;
                    tok_start = pos_sat(cur + 2);
                    close_q   = 0;
                end
                fields_expected.push_back(d);
            end
            for (int j = HIST - 1; j > 0; j--)
                hist[j] = hist[j - 1];
            hist[0] = hb;
        end
        if (last)
        begin
            row_num++;
            restart_line();
        end
        else
        begin
            if (pos >= SKIP_BYTES)
            begin
                hold_b = b;
                hold_v = 1'b1;
            end
            pos = pos_sat(pos + 1);
        end
    endtask

    function automatic int pick_gap();
        int p;
        if (gaps_off)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        split_predict(b, last);
        bytes_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            push_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_line();
    endtask

    // Drop valid, then wait until every descriptor has come out and the pipe is empty
    task automatic finish_phase();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (fields_expected.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_column_count(input int v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[CFG_BITS-1:0];
        col_cfg     = v[CFG_BITS-1:0];
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_plain_fields();
        write_column_count(4);
        send_text("##ab,,NULL,x!");
        send_text("zzNULL!");
        send_text("~~NUL,NULLX,null, NULL!");
        send_text("##1234,,,!");
        finish_phase();
    endtask

    task automatic test_quoting();
        write_column_count(4);
        send_text("##\"a,b\",\"c\\\"d\",e!");
        send_text("##\"x\\\\\",y,\"\\,\"!");
        send_text("##\"\"\"\"\"\"\"\"\"\"\"\"\"\"\"\"\"\"z,a!");
        send_text("##\"NULL\",\"NULL\"\"\"\"\"\"\"\"\",b!");
        send_text("##\"N\"\"U\"\"L\"\"L\",NU\"\"LL,q!");
        send_text("##\"open,never,closed!");
        finish_phase();
    endtask

    task automatic test_short_lines();
        write_column_count(2);
        send_text("!");
        send_text("a!");
        send_text("ab!");
        send_text("abc!");
        send_text("#,!");
        send_text("##,!");
        finish_phase();
    endtask

    task automatic test_column_limits();
        // zero flags the very first field of every line
        write_column_count(0);
        send_text("##a,b!");
        send_text("##!!");
        finish_phase();
        write_column_count(1);
        send_text("##a,b,c,d!");
        send_text("##only!");
        finish_phase();
        // counts above the maximum act as the maximum
        write_column_count(511);
        push_text("##");
        for (int i = 0; i < 258; i++)
            line_buf.push_back(CHAR_COMMA);
        push_text("!");
        send_line();
        finish_phase();
    endtask

    task automatic test_backpressure();
        write_column_count(256);
        gaps_off = 1'b1;
        hold_off = 40;
        push_text("##");
        for (int i = 0; i < 12; i++)
            line_buf.push_back((i % 3 == 0) ? CHAR_COMMA : 8'h61);
        push_text(",!");
        send_line();
        gaps_off = 1'b0;
        finish_phase();
    endtask

    task automatic build_random_line();
        string alpha;
        int    nf;
        int    n;
        alpha = "abNUL1 _x";
        line_buf.push_back(8'($urandom_range(0, 255)));
        line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            nf = $urandom_range(1, 6);
            for (int k = 0; k < nf; k++)
            begin
                if (k > 0)
                    line_buf.push_back(CHAR_COMMA);
                case ($urandom_range(0, 6))
                    0: ;
                    1: push_text("NULL");
                    2: push_text("\"NULL\"");
                    3:
                    begin
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++)
                            line_buf.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
                    end
                    4:
                    begin
                        line_buf.push_back(CHAR_QUOTE);
                        n = $urandom_range(0, 6);
                        for (int i = 0; i < n; i++)
                        begin
                            r = $urandom_range(0, 99);
                            if (r < 20)
                            begin
                                line_buf.push_back(CHAR_BSLASH);
                                line_buf.push_back(8'($urandom_range(0, 255)));
                            end
                            else if (r < 35)
                                push_text("\"\"");
                            else if (r < 50)
                                line_buf.push_back(CHAR_COMMA);
                            else
                                line_buf.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
                        end
                        line_buf.push_back(CHAR_QUOTE);
                    end
                    5:
                    begin
                        n = $urandom_range(1, 4);
                        for (int i = 0; i < n; i++)
                            line_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    default: push_text(($urandom_range(0, 1) == 1) ? "NUL" : "NULLX");
                endcase
            end
        end
        line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_lines();
        int cfgs [4];
        int target;
        cfgs = '{3, 1, 300, 2};
        for (int p = 0; p < 4; p++)
        begin
            write_column_count(cfgs[p]);
            gaps_off  = (p == 1);
            rx_steady = (p == 2);
            target    = bytes_sent + 8;
            while (bytes_sent < target)
            begin
                build_random_line();
                send_line();
            end
            finish_phase();
        end
        gaps_off  = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 18)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (fields_expected.size() == 0)
            begin
                errors++;
                $display("%0t ns: descriptor with none expected, tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = fields_expected.pop_front();
                compare_field("row_index", 32'(want.row_index), 32'(m_tdata[23:0]));
                compare_field("column_index", 32'(want.column_index),
                              32'(m_tdata[31:24]));
                compare_field("field_start", 32'(want.field_start), 32'(m_tdata[47:32]));
                compare_field("field_length", 32'(want.field_length),
                              32'(m_tdata[63:48]));
                compare_field("is_null", 32'(want.is_null), 32'(m_tdata[64]));
                compare_field("too_many_columns", 32'(want.too_many_columns),
                              32'(m_tuser[0]));
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        errors      = 0;
        bytes_sent  = 0;
        gaps_off    = 1'b0;
        rx_steady   = 1'b0;
        hold_off    = 0;
        stall_left  = 0;
        reset_splitter_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plain_fields();
        test_quoting();
        test_short_lines();
        test_column_limits();
        test_backpressure();
        test_random_lines();

        if (errors == 0 && fields_expected.size() == 0)
            $display("PASS result_row_field_splitter");
        else
            $display("FAIL result_row_field_splitter");
        $finish;
    end

endmodule
